// ===== src/modexp_pkg.sv =====
package modexp_pkg;

    // width of the base, exponent and result fields
    localparam int DATA_W = 32;
    // bit counter of the shift-add multiplier, one step per bit of the left operand
    localparam int CNT_W = $clog2(DATA_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL_ACC,
        ST_SQUARE
    } state_t;

    typedef struct packed {
        logic load;
        logic start_acc;
        logic start_sq;
        logic take_base;
        logic take_acc;
        logic shift_exp;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic mul_last;
        logic exp_zero;
        logic exp_lsb;
        logic out_free;
    } status_t;

endpackage

// ===== src/modexp_if.sv =====
interface modexp_in_if;
    logic                            valid;
    logic                            ready;
    logic [modexp_pkg::DATA_W-1:0]   base_value;
    logic [modexp_pkg::DATA_W-1:0]   exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink (input valid, input base_value, input exponent, output ready);
endinterface

interface modexp_out_if;
    logic                            valid;
    logic                            ready;
    logic [modexp_pkg::DATA_W-1:0]   power_result;

    modport source (output valid, output power_result, input ready);
    modport sink (input valid, input power_result, output ready);
endinterface

// ===== src/modexp_ctrl.sv =====
module modexp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  modexp_pkg::status_t  status,
    output modexp_pkg::cmd_t     cmd
);

    modexp_pkg::state_t state_reg;
    modexp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= modexp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            modexp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = modexp_pkg::ST_REDUCE;
                end
            end
            modexp_pkg::ST_REDUCE:
            begin
                if (status.mul_last)
                begin
                    cmd.take_base = 1'b1;
                    state_next    = modexp_pkg::ST_CHECK;
                end
            end
            modexp_pkg::ST_CHECK:
            begin
                if (status.exp_zero)
                begin
                    // wait here until the output register can take the result
                    if (status.out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = modexp_pkg::ST_IDLE;
                    end
                end
                else if (status.exp_lsb)
                begin
                    cmd.start_acc = 1'b1;
                    state_next    = modexp_pkg::ST_MUL_ACC;
                end
                else
                begin
                    cmd.start_sq = 1'b1;
                    state_next   = modexp_pkg::ST_SQUARE;
                end
            end
            modexp_pkg::ST_MUL_ACC:
            begin
                if (status.mul_last)
                begin
                    // base is unchanged, so the square starts right away
                    cmd.take_acc = 1'b1;
                    cmd.start_sq = 1'b1;
                    state_next   = modexp_pkg::ST_SQUARE;
                end
            end
            modexp_pkg::ST_SQUARE:
            begin
                if (status.mul_last)
                begin
                    cmd.take_base = 1'b1;
                    cmd.shift_exp = 1'b1;
                    state_next    = modexp_pkg::ST_CHECK;
                end
            end
            default:
            begin
                state_next = modexp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/modexp_datapath.sv =====
module modexp_datapath #(
    parameter int WIDTH    = 32,
    parameter int EXP_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  modexp_pkg::cmd_t                cmd,
    output modexp_pkg::status_t             status,
    input  logic [modexp_pkg::DATA_W-1:0]   base_value,
    input  logic [modexp_pkg::DATA_W-1:0]   exponent,
    input  logic                            cfg_we,
    input  logic [modexp_pkg::DATA_W-1:0]   cfg_wdata,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [modexp_pkg::DATA_W-1:0]   power_result
);

    localparam int RW = WIDTH + 2;

    logic [WIDTH-1:0]                mod_reg;
    logic [WIDTH-1:0]                cfg_low;
    logic [modexp_pkg::DATA_W-1:0]   a_reg;
    logic [WIDTH-1:0]                b_reg;
    logic [WIDTH-1:0]                r_reg;
    logic [WIDTH-1:0]                r_next;
    logic [modexp_pkg::CNT_W-1:0]    cnt_reg;
    logic                            busy_reg;
    logic [WIDTH-1:0]                base_reg;
    logic [WIDTH-1:0]                acc_reg;
    logic [EXP_BITS-1:0]             exp_reg;
    logic                            out_valid_reg;
    logic [modexp_pkg::DATA_W-1:0]   power_result_reg;

    logic [WIDTH-1:0]                addend;
    logic [RW-1:0]                   sum;
    logic [RW:0]                     diff1;
    logic [RW:0]                     diff2;

    // one step of the shift-add multiplier: r = 2r + bit*b, then bring it back below m
    // with r < m and b <= m the sum stays below 3m, so at most 2m comes off
    always_comb
    begin
        addend = a_reg[modexp_pkg::DATA_W-1] ? b_reg : '0;
        sum    = RW'({r_reg, 1'b0}) + RW'(addend);
        diff1  = {1'b0, sum} - (RW + 1)'(mod_reg);
        diff2  = {1'b0, sum} - (RW + 1)'({mod_reg, 1'b0});
        if (!diff2[RW])
        begin
            r_next = diff2[WIDTH-1:0];
        end
        else if (!diff1[RW])
        begin
            r_next = diff1[WIDTH-1:0];
        end
        else
        begin
            r_next = sum[WIDTH-1:0];
        end
    end

    assign cfg_low = cfg_wdata[WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg       <= WIDTH'(23);
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mod_reg <= (cfg_low == '0) ? WIDTH'(1) : cfg_low;
            end
            if (cmd.load || cmd.start_acc || cmd.start_sq)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            // reduce the base first: base * 1 mod m on the same unit
            a_reg <= base_value;
            b_reg <= WIDTH'(1);
            r_reg <= '0;
        end
        else if (cmd.start_acc)
        begin
            a_reg <= modexp_pkg::DATA_W'(acc_reg);
            b_reg <= base_reg;
            r_reg <= '0;
        end
        else if (cmd.start_sq)
        begin
            a_reg <= modexp_pkg::DATA_W'(base_reg);
            b_reg <= base_reg;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_reg <= {a_reg[modexp_pkg::DATA_W-2:0], 1'b0};
            r_reg <= r_next;
        end

        if (cmd.load)
        begin
            acc_reg <= WIDTH'(1);
            exp_reg <= exponent[EXP_BITS-1:0];
        end
        else
        begin
            if (cmd.take_acc)
            begin
                acc_reg <= r_next;
            end
            if (cmd.shift_exp)
            begin
                exp_reg <= exp_reg >> 1;
            end
        end

        if (cmd.take_base)
        begin
            base_reg <= r_next;
        end

        if (cmd.load_out)
        begin
            power_result_reg <= modexp_pkg::DATA_W'(acc_reg);
        end
    end

    assign status.mul_last = busy_reg && (cnt_reg == '0);
    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_lsb  = exp_reg[0];
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign power_result = power_result_reg;

endmodule

// ===== src/modular_exponentiation.sv =====
// right-to-left square-and-multiply, one item at a time; every modular product runs on one
// shift-add multiplier, one bit of the left operand per cycle; an item first reduces the
// base, then for each exponent bit up to the highest set one multiplies the accumulator
// by the base if that bit is set and then squares the base
// a new item is accepted the cycle after the result enters the output register
// reset (async, active low): idle, output empty, modulus back to 23
module modular_exponentiation #(
    parameter int WIDTH     = 32,
    parameter int EXP_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    modexp_in_if.sink                       req,
    modexp_out_if.source                    rsp,
    input  logic                            cfg_we,
    input  logic [modexp_pkg::DATA_W-1:0]   cfg_wdata
);

    // only exponent bits that the field actually carries are used
    localparam int EXP_BITS = (EXP_WIDTH < modexp_pkg::DATA_W) ? EXP_WIDTH : modexp_pkg::DATA_W;

    modexp_pkg::cmd_t    cmd;
    modexp_pkg::status_t status;

    modexp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    modexp_datapath #(
        .WIDTH    (WIDTH),
        .EXP_BITS (EXP_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .base_value   (req.base_value),
        .exponent     (req.exponent),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_ready    (rsp.ready),
        .out_valid    (rsp.valid),
        .power_result (rsp.power_result)
    );

endmodule
